@@ rtl/ldu_smv_pkg.sv @@
package ldu_smv_pkg;

  localparam int unsigned OpW      = 2;
  localparam int unsigned IdxW     = 10;
  localparam int unsigned CoefW    = 32;
  localparam int unsigned SumW     = 48;
  localparam int unsigned ProdW    = 2 * CoefW;
  localparam int unsigned FracBits = 16;
  localparam int unsigned CellsW   = 11;
  localparam int unsigned FacesW   = 16;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  localparam int unsigned MaxCellsDefault = 1024;
  localparam int unsigned IdxSpan         = 1 << IdxW;

  localparam logic [OpW-1:0] OpLoad = 2'd0;
  localparam logic [OpW-1:0] OpFace = 2'd1;
  localparam logic [OpW-1:0] OpRead = 2'd2;

  localparam logic [CfgIdxW-1:0] RegCellsInUse  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegCoupledFaces = 1'b1;

  localparam logic [CellsW-1:0] CellsReset = 11'd1024;

  localparam logic signed [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
  localparam logic signed [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};

  function automatic logic signed [SumW-1:0] sat_add(logic signed [SumW-1:0] a,
                                                    logic signed [SumW-1:0] b);
    logic [SumW:0] s;
    s = {a[SumW-1], a} + {b[SumW-1], b};
    if (s[SumW] != s[SumW-1]) begin
      return s[SumW] ? SumMin : SumMax;
    end
    return s[SumW-1:0];
  endfunction

endpackage

@@ rtl/ldu_sparse_matvec.sv @@
// A read returns its result on the ports in the cycle after the start transaction.
// Reads pass StRead, cell loads StMul and StAdd1, faces StMul, StAdd1 and StAdd2, set by
// the single write port of the y memory and the multiply stage; ignored items keep it idle.
// Reset idles the FSM, clears faces_q and coupled_q and sets cells_q to 1024; the x and y
// memories are not cleared. The receiver cannot stall: result_valid_o lasts one cycle.
module ldu_sparse_matvec #(
  parameter int unsigned MAX_CELLS = ldu_smv_pkg::MaxCellsDefault
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  logic                                  cfg_we_i,
  input  logic [ldu_smv_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [ldu_smv_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic [ldu_smv_pkg::OpW-1:0]           operation_i,
  input  logic [ldu_smv_pkg::IdxW-1:0]          first_index_i,
  input  logic [ldu_smv_pkg::IdxW-1:0]          second_index_i,
  input  logic signed [ldu_smv_pkg::CoefW-1:0]  coef_a_i,
  input  logic signed [ldu_smv_pkg::CoefW-1:0]  coef_b_i,
  input  logic signed [ldu_smv_pkg::CoefW-1:0]  x_value_i,
  output logic                                  result_valid_o,
  output logic signed [ldu_smv_pkg::SumW-1:0]   sum_value_o,
  output logic                                  index_error_o,
  output logic                                  pass_complete_o
);
  import ldu_smv_pkg::*;

  localparam int unsigned Depth = (MAX_CELLS < IdxSpan) ? MAX_CELLS : IdxSpan;
  localparam int unsigned AW    = $clog2(Depth);
  localparam logic [CellsW-1:0] DepthLimit = CellsW'(Depth);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StAdd1 = 3'd2;
  localparam logic [2:0] StAdd2 = 3'd3;
  localparam logic [2:0] StRead = 3'd4;

  logic [2:0] state_q, state_d;

  logic [CellsW-1:0] cells_q;
  logic [FacesW-1:0] coupled_q;
  logic [FacesW-1:0] faces_q;

  logic signed [CoefW-1:0] x_mem [Depth];
  logic signed [SumW-1:0]  y_mem [Depth];

  logic signed [CoefW-1:0] x1_rd_q, x2_rd_q;
  logic signed [SumW-1:0]  y1_rd_q, y2_rd_q;

  logic                    is_load_q;
  logic                    ok1_q;
  logic [IdxW-1:0]         i1_q, i2_q;
  logic signed [CoefW-1:0] coef_a_q, coef_b_q, x_val_q;
  logic signed [ProdW-1:0] prod_a_q, prod_b_q;
  logic signed [SumW-1:0]  y_new_q;

  logic accept;
  logic ok1, ok2;
  logic load_ok, face_ok;
  logic signed [CoefW-1:0] mul_b;
  logic signed [SumW-1:0]  add1_base, add1_sum, add2_base, add2_sum;

  assign accept  = start_i && !busy_o;
  assign busy_o  = (state_q != StIdle);
  assign ok1     = ({1'b0, first_index_i} < cells_q) && ({1'b0, first_index_i} < DepthLimit);
  assign ok2     = ({1'b0, second_index_i} < cells_q) && ({1'b0, second_index_i} < DepthLimit);
  assign load_ok = accept && (operation_i == OpLoad) && ok1;
  assign face_ok = accept && (operation_i == OpFace) && ok1 && ok2;

  assign mul_b     = is_load_q ? x_val_q : x2_rd_q;
  assign add1_base = is_load_q ? '0 : y1_rd_q;
  assign add1_sum  = sat_add(add1_base, prod_a_q[ProdW-1:FracBits]);
  assign add2_base = (i1_q == i2_q) ? y_new_q : y2_rd_q;
  assign add2_sum  = sat_add(add2_base, prod_b_q[ProdW-1:FracBits]);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (operation_i == OpRead) begin
            state_d = StRead;
          end else if (load_ok || face_ok) begin
            state_d = StMul;
          end
        end
      end
      StMul:   state_d = StAdd1;
      StAdd1:  state_d = is_load_q ? StIdle : StAdd2;
      StAdd2:  state_d = StIdle;
      StRead:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      cells_q   <= CellsReset;
      coupled_q <= '0;
      faces_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          RegCellsInUse:   cells_q   <= cfg_data_i[CellsW-1:0];
          RegCoupledFaces: coupled_q <= cfg_data_i[FacesW-1:0];
          default:         ;
        endcase
      end
      if (load_ok) begin
        faces_q <= '0;
      end else if (face_ok && (faces_q != {FacesW{1'b1}})) begin
        faces_q <= faces_q + FacesW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      is_load_q <= (operation_i == OpLoad);
      ok1_q     <= ok1;
      i1_q      <= first_index_i;
      i2_q      <= second_index_i;
      coef_a_q  <= coef_a_i;
      coef_b_q  <= coef_b_i;
      x_val_q   <= x_value_i;
    end
    if (state_q == StMul) begin
      prod_a_q <= coef_a_q * mul_b;
      prod_b_q <= coef_b_q * x1_rd_q;
    end
    if (state_q == StAdd1) begin
      y_new_q <= add1_sum;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_ok) begin
      x_mem[first_index_i[AW-1:0]] <= x_value_i;
    end
    if (accept) begin
      x1_rd_q <= x_mem[first_index_i[AW-1:0]];
      x2_rd_q <= x_mem[second_index_i[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StAdd1) begin
      y_mem[i1_q[AW-1:0]] <= add1_sum;
    end else if (state_q == StAdd2) begin
      y_mem[i2_q[AW-1:0]] <= add2_sum;
    end
    if (accept) begin
      y1_rd_q <= y_mem[first_index_i[AW-1:0]];
      y2_rd_q <= y_mem[second_index_i[AW-1:0]];
    end
  end

  assign result_valid_o  = (state_q == StRead);
  assign sum_value_o     = ok1_q ? y1_rd_q : '0;
  assign index_error_o   = !ok1_q;
  assign pass_complete_o = (faces_q >= coupled_q);

endmodule
